FILE: sv/sabcd_pkg.sv
// Shared types, widths and codes for the S-to-ABCD conversion unit.
`default_nettype none
package sabcd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_P1_RE = 2'd0;
  localparam logic [1:0] REG_P1_IM = 2'd1;
  localparam logic [1:0] REG_P2_RE = 2'd2;
  localparam logic [1:0] REG_P2_IM = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Reset values of the reference impedances and of their square root
  localparam logic [15:0] REF_RE_RESET = 16'd3200;
  localparam int          SQ_W         = 24;
  localparam logic [SQ_W-1:0] SQ_RESET = 24'd819200;

  // Datapath widths
  localparam logic signed [17:0] ONE_Q13 = 18'sd8192;
  localparam int NUM_W = 50;   // numerator entries NA..ND
  localparam int P_W   = 67;   // numerator times conj(S21)
  localparam int U_W   = 67;   // its magnitude
  localparam int DEN_W = 57;   // 2*sq*|S21|^2
  localparam int QB    = 33;   // quotient bits, one below output LSB
  localparam int OUT_W = 32;

  // Fraction shifts of the four entries
  localparam int K_AD = 17;
  localparam int K_B  = 27;
  localparam int K_C  = 29;

  // Pipeline depths
  localparam int NUMER_LAT = 5;
  localparam int DIV_LAT   = QB + 2;
  localparam int LATENCY   = NUMER_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [15:0] s11_re;
    logic signed [15:0] s11_im;
    logic signed [15:0] s12_re;
    logic signed [15:0] s12_im;
    logic signed [15:0] s21_re;
    logic signed [15:0] s21_im;
    logic signed [15:0] s22_re;
    logic signed [15:0] s22_im;
  } smat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] a_re;
    logic signed [OUT_W-1:0] a_im;
    logic signed [OUT_W-1:0] b_re;
    logic signed [OUT_W-1:0] b_im;
    logic signed [OUT_W-1:0] c_re;
    logic signed [OUT_W-1:0] c_im;
    logic signed [OUT_W-1:0] d_re;
    logic signed [OUT_W-1:0] d_im;
    logic [1:0]              status;
  } abcd_t;

  typedef struct packed {
    logic [15:0]        z1_re;
    logic signed [15:0] z1_im;
    logic [15:0]        z2_re;
    logic signed [15:0] z2_im;
    logic [SQ_W-1:0]    sq;
  } ref_t;

  typedef struct packed {
    logic           neg;
    logic [U_W-1:0] mag;
  } part_t;

  typedef struct packed {
    part_t [7:0]      part;
    logic [DEN_W-1:0] den;
    logic             dz;
  } num_t;

endpackage
`default_nettype wire

FILE: sv/sabcd_cfg.sv
// Reference impedance registers and the iterative square root of Re Z1 * Re Z2 * 2^16.
`default_nettype none
module sabcd_cfg
  import sabcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output ref_t        cfg,
  output logic        busy
);

  logic [15:0]        r1, r2;
  logic signed [15:0] i1, i2;
  logic [SQ_W-1:0]    sq;
  logic               running;
  logic [4:0]         cnt;
  logic [47:0]        v;
  logic [25:0]        rem;
  logic [SQ_W-1:0]    root;

  logic [15:0] r1_new, r2_new;
  logic        kick;
  logic [27:0] rem_n, trial;
  logic        take;

  // Pick up the new real parts and one root digit per cycle while the root runs
  always_comb begin
    r1_new = (wr_en && wr_index == REG_P1_RE) ? wr_data : r1;
    r2_new = (wr_en && wr_index == REG_P2_RE) ? wr_data : r2;
    kick   = wr_en && (wr_index == REG_P1_RE || wr_index == REG_P2_RE);
    rem_n  = {rem, v[47:46]};
    trial  = {2'b00, root, 2'b01};
    take   = rem_n >= trial;
  end

  // Hold registers; restart the root on every real-part write
  always_ff @(posedge clk) begin
    if (rst) begin
      r1      <= REF_RE_RESET;
      i1      <= '0;
      r2      <= REF_RE_RESET;
      i2      <= '0;
      sq      <= SQ_RESET;
      running <= 1'b0;
      cnt     <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_P1_RE: r1 <= wr_data;
          REG_P1_IM: i1 <= signed'(wr_data);
          REG_P2_RE: r2 <= wr_data;
          REG_P2_IM: i2 <= signed'(wr_data);
          default: ;
        endcase
      end
      if (kick) begin
        v       <= {32'(r1_new) * 32'(r2_new), 16'h0000};
        rem     <= '0;
        root    <= '0;
        cnt     <= 5'(SQ_W);
        running <= 1'b1;
      end else if (running) begin
        v    <= {v[45:0], 2'b00};
        rem  <= take ? 26'(rem_n - trial) : 26'(rem_n);
        root <= {root[SQ_W-2:0], take};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          running <= 1'b0;
          sq      <= {root[SQ_W-2:0], take};
        end
      end
    end
  end

  assign cfg  = '{z1_re: r1, z1_im: i1, z2_re: r2, z2_im: i2, sq: sq};
  assign busy = running;

endmodule
`default_nettype wire

FILE: sv/sabcd_numer.sv
// Five-stage numerator pipeline: ABCD numerators times conj(S21) and the denominator.
`default_nettype none
module sabcd_numer
  import sabcd_pkg::*;
(
  input  logic  clk,
  input  smat_t smat,
  input  ref_t  cfg,
  output num_t  num
);

  logic signed [17:0] z1r, z1i, z2r, z2i;
  assign z1r = signed'({2'b00, cfg.z1_re});
  assign z1i = 18'(cfg.z1_im);
  assign z2r = signed'({2'b00, cfg.z2_re});
  assign z2i = 18'(cfg.z2_im);

  // Stage 1: P1, P2, 1-S, S12*S21, Z1*Z2, |S21|^2
  logic signed [34:0] p1r, p1i, p2r, p2i;
  logic signed [17:0] q1r, q1i, q3r, q3i;
  logic signed [33:0] tr, ti;
  logic signed [37:0] zzr, zzi;
  logic [31:0]        mag2;
  logic signed [15:0] s1r, s1i;
  logic signed [32:0] mag2_w;

  assign mag2_w = smat.s21_re * smat.s21_re + smat.s21_im * smat.s21_im;

  always_ff @(posedge clk) begin
    p1r  <= ONE_Q13 * z1r + smat.s11_re * z1r - smat.s11_im * z1i;
    p1i  <= -(ONE_Q13 * z1i) + smat.s11_re * z1i + smat.s11_im * z1r;
    p2r  <= ONE_Q13 * z2r + smat.s22_re * z2r - smat.s22_im * z2i;
    p2i  <= -(ONE_Q13 * z2i) + smat.s22_re * z2i + smat.s22_im * z2r;
    q1r  <= ONE_Q13 - smat.s22_re;
    q1i  <= -smat.s22_im;
    q3r  <= ONE_Q13 - smat.s11_re;
    q3i  <= -smat.s11_im;
    tr   <= smat.s12_re * smat.s21_re - smat.s12_im * smat.s21_im;
    ti   <= smat.s12_re * smat.s21_im + smat.s12_im * smat.s21_re;
    zzr  <= z1r * z2r - z1i * z2i;
    zzi  <= z1r * z2i + z1i * z2r;
    mag2 <= mag2_w[31:0];
    s1r  <= smat.s21_re;
    s1i  <= smat.s21_im;
  end

  // Stage 2: complex products and the denominator
  logic signed [31:0] p1sr, p1si, p2sr, p2si;
  logic signed [27:0] tsr, tsi;
  assign p1sr = 32'(p1r >>> 3);
  assign p1si = 32'(p1i >>> 3);
  assign p2sr = 32'(p2r >>> 3);
  assign p2si = 32'(p2i >>> 3);
  assign tsr  = 28'(tr >>> 6);
  assign tsi  = 28'(ti >>> 6);

  logic signed [53:0] pq1r, pq1i, q3p2r, q3p2i;
  logic signed [52:0] tz1r, tz1i, tz2r, tz2i;
  logic signed [36:0] qqr, qqi;
  logic signed [64:0] ppr, ppi;
  logic signed [66:0] tzzr, tzzi;
  logic signed [33:0] tr2, ti2;
  logic signed [15:0] s2r, s2i;
  logic [DEN_W-1:0]   den2;
  logic               dz2;

  always_ff @(posedge clk) begin
    pq1r  <= p1r * q1r - p1i * q1i;
    pq1i  <= p1r * q1i + p1i * q1r;
    tz1r  <= tr * z1r - ti * z1i;
    tz1i  <= tr * z1i + ti * z1r;
    qqr   <= q3r * q1r - q3i * q1i;
    qqi   <= q3r * q1i + q3i * q1r;
    q3p2r <= q3r * p2r - q3i * p2i;
    q3p2i <= q3r * p2i + q3i * p2r;
    tz2r  <= tr * z2r - ti * z2i;
    tz2i  <= tr * z2i + ti * z2r;
    ppr   <= p1sr * p2sr - p1si * p2si;
    ppi   <= p1sr * p2si + p1si * p2sr;
    tzzr  <= tsr * zzr - tsi * zzi;
    tzzi  <= tsr * zzi + tsi * zzr;
    tr2   <= tr;
    ti2   <= ti;
    s2r   <= s1r;
    s2i   <= s1i;
    den2  <= DEN_W'({cfg.sq, 1'b0}) * DEN_W'(mag2);
    dz2   <= (cfg.sq == '0) || (mag2 == '0);
  end

  // Stage 3: sum and scale the numerators
  logic signed [54:0] naw_r, naw_i, ndw_r, ndw_i;
  logic signed [67:0] nbw_r, nbw_i;
  logic signed [37:0] ncw_r, ncw_i;
  assign naw_r = pq1r + tz1r;
  assign naw_i = pq1i + tz1i;
  assign ndw_r = q3p2r + tz2r;
  assign ndw_i = q3p2i + tz2i;
  assign nbw_r = ppr - tzzr;
  assign nbw_i = ppi - tzzi;
  assign ncw_r = qqr - tr2;
  assign ncw_i = qqi - ti2;

  logic signed [NUM_W-1:0] n3 [8];
  logic signed [15:0]      s3r, s3i;
  logic [DEN_W-1:0]        den3;
  logic                    dz3;

  always_ff @(posedge clk) begin
    n3[0] <= NUM_W'(naw_r >>> 6);
    n3[1] <= NUM_W'(naw_i >>> 6);
    n3[2] <= NUM_W'(nbw_r >>> 16);
    n3[3] <= NUM_W'(nbw_i >>> 16);
    n3[4] <= NUM_W'(ncw_r);
    n3[5] <= NUM_W'(ncw_i);
    n3[6] <= NUM_W'(ndw_r >>> 6);
    n3[7] <= NUM_W'(ndw_i >>> 6);
    s3r   <= s2r;
    s3i   <= s2i;
    den3  <= den2;
    dz3   <= dz2;
  end

  // Stage 4: multiply each entry by conj(S21)
  logic signed [P_W-1:0] p4 [8];
  logic [DEN_W-1:0]      den4;
  logic                  dz4;

  always_ff @(posedge clk) begin
    for (int e = 0; e < 4; e++) begin
      p4[2*e]   <= n3[2*e] * s3r + n3[2*e+1] * s3i;
      p4[2*e+1] <= n3[2*e+1] * s3r - n3[2*e] * s3i;
    end
    den4 <= den3;
    dz4  <= dz3;
  end

  // Stage 5: split into sign and magnitude
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      num.part[7-i].neg <= p4[i][P_W-1];
      num.part[7-i].mag <= U_W'(p4[i][P_W-1] ? -p4[i] : p4[i]);
    end
    num.den <= den4;
    num.dz  <= dz4;
  end

endmodule
`default_nettype wire

FILE: sv/sabcd_div.sv
// Pipelined restoring divider: one quotient bit per stage, then round and saturate.
`default_nettype none
module sabcd_div
  import sabcd_pkg::*;
#(
  parameter int K = K_AD
)
(
  input  logic                    clk,
  input  logic                    neg,
  input  logic [U_W-1:0]          mag,
  input  logic [DEN_W-1:0]        den,
  output logic signed [OUT_W-1:0] res,
  output logic                    sat
);

  localparam int XW = U_W + K + 1;

  logic [XW-1:0]    rem  [QB+1];
  logic [QB-1:0]    quo  [QB+1];
  logic [DEN_W-1:0] dens [QB+1];
  logic             negs [QB+1];
  logic             ovfs [QB+1];

  logic [XW-1:0] x0;
  assign x0 = XW'(mag) << (K + 1);

  // Scale the dividend, flag a quotient too large, then one bit per stage
  always_ff @(posedge clk) begin
    rem[0]  <= x0;
    quo[0]  <= '0;
    dens[0] <= den;
    negs[0] <= neg;
    ovfs[0] <= (x0 >> QB) >= XW'(den);
    for (int i = 0; i < QB; i++) begin
      if ((rem[i] >> (QB - 1 - i)) >= XW'(dens[i])) begin
        rem[i+1] <= rem[i] - (XW'(dens[i]) << (QB - 1 - i));
        quo[i+1] <= {quo[i][QB-2:0], 1'b1};
      end else begin
        rem[i+1] <= rem[i];
        quo[i+1] <= {quo[i][QB-2:0], 1'b0};
      end
      dens[i+1] <= dens[i];
      negs[i+1] <= negs[i];
      ovfs[i+1] <= ovfs[i];
    end
  end

  // Round half away from zero and clamp to 32 bits
  logic [QB:0]       qr;
  logic [QB-1:0]     magr, lim;
  logic [OUT_W-1:0]  m32;
  logic              over;
  always_comb begin
    qr   = {1'b0, quo[QB]} + {{QB{1'b0}}, 1'b1};
    magr = qr[QB:1];
    lim  = negs[QB] ? (QB'(1) << (OUT_W - 1)) : ((QB'(1) << (OUT_W - 1)) - QB'(1));
    over = ovfs[QB] || (magr > lim);
    m32  = magr[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    sat <= over;
    if (over) begin
      res <= negs[QB] ? signed'({1'b1, {(OUT_W-1){1'b0}}})
                      : signed'({1'b0, {(OUT_W-1){1'b1}}});
    end else begin
      res <= signed'(negs[QB] ? (~m32 + 32'd1) : m32);
    end
  end

endmodule
`default_nettype wire

FILE: sv/s_to_abcd_two_port_conversion_unit.sv
// Top level of the two-port S-to-ABCD conversion unit.
//
// Usage:
//   Input: drive smat and raise start; a word is taken at each rising edge
//   with start high and busy low. A new word may follow every cycle.
//   Output: each result word appears on abcd for one cycle with done high,
//   in input order. The receiver cannot stall; results are never held.
//   Throughput: one word per cycle while busy is low, set by a 5-stage
//   numerator pipeline followed by a 35-stage divider (one quotient bit per stage).
//   Configuration: wr_en/wr_index/wr_data write the reference impedances
//   (0: Re Z1, 1: Im Z1, 2: Re Z2, 3: Im Z2). A write to a real part
//   recomputes sqrt(Re Z1 Re Z2), during which busy is high.
//   Write configuration only with no words in flight.
//   Reset: synchronous; all words in flight are dropped, impedances return
//   to 50 ohm and busy is low in the following cycle.
`default_nettype none
module s_to_abcd_two_port_conversion_unit
  import sabcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  smat_t       smat,
  output logic        done,
  output abcd_t       abcd,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  ref_t cfg;
  num_t num;

  sabcd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg),
    .busy     (busy)
  );

  sabcd_numer u_numer (
    .clk  (clk),
    .smat (smat),
    .cfg  (cfg),
    .num  (num)
  );

  logic signed [OUT_W-1:0] res [8];
  logic [7:0]              sat;

  // One divider lane per real or imaginary part
  for (genvar i = 0; i < 8; i++) begin : g_div
    localparam int KI = (i < 2) ? K_AD : (i < 4) ? K_B : (i < 6) ? K_C : K_AD;
    sabcd_div #(.K(KI)) u_div (
      .clk (clk),
      .neg (num.part[7-i].neg),
      .mag (num.part[7-i].mag),
      .den (num.den),
      .res (res[i]),
      .sat (sat[i])
    );
  end

  // Track valid words and the zero-denominator flag alongside the data
  logic [LATENCY-1:0] vpipe;
  logic [DIV_LAT-1:0] dzpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    dzpipe <= {dzpipe[DIV_LAT-2:0], num.dz};
  end

  // Assemble the result word
  logic dz;
  assign dz   = dzpipe[DIV_LAT-1];
  assign done = vpipe[LATENCY-1];

  always_comb begin
    abcd.a_re   = dz ? '0 : res[0];
    abcd.a_im   = dz ? '0 : res[1];
    abcd.b_re   = dz ? '0 : res[2];
    abcd.b_im   = dz ? '0 : res[3];
    abcd.c_re   = dz ? '0 : res[4];
    abcd.c_im   = dz ? '0 : res[5];
    abcd.d_re   = dz ? '0 : res[6];
    abcd.d_im   = dz ? '0 : res[7];
    abcd.status = dz ? ST_DIVZ : ((|sat) ? ST_SAT : ST_OK);
  end

endmodule
`default_nettype wire

FILE: sv/sabcd_chk.sv
// Port-level checker for the S-to-ABCD conversion unit, bound to the top level.
`default_nettype none
module sabcd_chk
  import sabcd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input abcd_t      abcd,
  input logic       wr_en,
  input logic [1:0] wr_index
);

  // Drop everything in flight at reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !done)
    else $error("result word after reset");

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result word missing at fixed latency");

  // Status is a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (abcd.status == ST_OK || abcd.status == ST_DIVZ || abcd.status == ST_SAT))
    else $error("undefined status code");

  // Divide error zeroes the matrix
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && abcd.status == ST_DIVZ) |->
      (abcd.a_re == 0 && abcd.a_im == 0 && abcd.b_re == 0 && abcd.b_im == 0 &&
       abcd.c_re == 0 && abcd.c_im == 0 && abcd.d_re == 0 && abcd.d_im == 0))
    else $error("nonzero matrix on divide error");

  // A real-part write starts the root unit
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (wr_index == REG_P1_RE || wr_index == REG_P2_RE)) |=> busy)
    else $error("busy not raised after real-part write");

endmodule

bind s_to_abcd_two_port_conversion_unit sabcd_chk u_sabcd_chk (.*);
`default_nettype wire

FILE: verif/s_to_abcd_two_port_conversion_unit_test.sv
// Self-checking testbench for the two-port S-to-ABCD conversion unit.
`default_nettype none
module s_to_abcd_two_port_conversion_unit_test;
  import sabcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_WORDS  = 1250;

  typedef struct packed {
    logic signed [127:0] re;
    logic signed [127:0] im;
  } cx_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  smat_t       smat = '0;
  logic        done;
  abcd_t       abcd;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_P1_RE;
  logic [15:0] wr_data = '0;

  // Shadow copy of the reference impedances
  logic [15:0]        z1_re_q = REF_RE_RESET;
  logic signed [15:0] z1_im_q = '0;
  logic [15:0]        z2_re_q = REF_RE_RESET;
  logic signed [15:0] z2_im_q = '0;
  logic [63:0]        root_q  = 64'd819200;

  abcd_t pending_abcd[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    idle_en = 1'b1;

  s_to_abcd_two_port_conversion_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .smat(smat),
    .done(done), .abcd(abcd), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #2 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic cx_t cx_mul(cx_t a, cx_t b);
    cx_t r;
    r.re = a.re * b.re - a.im * b.im;
    r.im = a.re * b.im + a.im * b.re;
    return r;
  endfunction

  function automatic cx_t cx_shr(cx_t a, int n);
    cx_t r;
    r.re = a.re >>> n;
    r.im = a.im >>> n;
    return r;
  endfunction

  // Round num*2^k/den to nearest, ties away from zero, saturate to 32 bits
  function automatic logic [31:0] round_quot(logic signed [127:0] num,
                                             logic [127:0] den, int k,
                                             inout bit sat);
    bit           neg;
    bit           big;
    logic [127:0] u, q, r, lim, mag;
    neg = num < 0;
    u = neg ? -num : num;
    q = u / den;
    r = u % den;
    lim = (128'd1 << 31) - (neg ? 128'd0 : 128'd1);
    big = q >= (128'd1 << 34);
    for (int i = 0; i <= k && !big; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 128'd1;
      end
      if (q >= (128'd1 << 34)) big = 1'b1;
    end
    mag = big ? lim + 1 : (q + 1) >> 1;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  // Divide one entry by 2*sq*S21 as N*conj(S21)/(2*sq*|S21|^2)
  function automatic logic [63:0] div_entry(cx_t n, cx_t s, logic [127:0] den,
                                            int k, inout bit sat);
    logic signed [127:0] pr, pi;
    logic [31:0]         qr, qi;
    pr = n.re * s.re + n.im * s.im;
    pi = n.im * s.re - n.re * s.im;
    qr = round_quot(pr, den, k, sat);
    qi = round_quot(pi, den, k, sat);
    return {qr, qi};
  endfunction

  function automatic abcd_t convert_smat(smat_t m);
    abcd_t        res;
    cx_t          s11, s12, s21, s22, z1, z2, p1, p2, q1, q3, t, na, nb, nc, nd;
    cx_t          tz1, tz2, zz, tzz;
    logic [127:0] mag2, den;
    logic [63:0]  ent;
    bit           sat;
    res = '0;
    sat = 1'b0;
    s11.re = $signed(m.s11_re); s11.im = $signed(m.s11_im);
    s12.re = $signed(m.s12_re); s12.im = $signed(m.s12_im);
    s21.re = $signed(m.s21_re); s21.im = $signed(m.s21_im);
    s22.re = $signed(m.s22_re); s22.im = $signed(m.s22_im);
    z1.re = $signed({112'd0, z1_re_q}); z1.im = z1_im_q;
    z2.re = $signed({112'd0, z2_re_q}); z2.im = z2_im_q;
    mag2 = s21.re * s21.re + s21.im * s21.im;
    if (root_q == 0 || mag2 == 0) begin
      res.status = ST_DIVZ;
      return res;
    end
    den = 128'd2 * {64'd0, root_q} * mag2;
    p1 = cx_mul(s11, z1);
    p1.re = p1.re + z1.re * 8192;
    p1.im = p1.im - z1.im * 8192;
    p2 = cx_mul(s22, z2);
    p2.re = p2.re + z2.re * 8192;
    p2.im = p2.im - z2.im * 8192;
    q1.re = 8192 - s22.re; q1.im = -s22.im;
    q3.re = 8192 - s11.re; q3.im = -s11.im;
    t = cx_mul(s12, s21);
    tz1 = cx_mul(t, z1);
    tz2 = cx_mul(t, z2);
    zz = cx_mul(z1, z2);
    tzz = cx_mul(cx_shr(t, 6), zz);
    na = cx_mul(p1, q1);
    na.re = na.re + tz1.re; na.im = na.im + tz1.im;
    na = cx_shr(na, 6);
    nb = cx_mul(cx_shr(p1, 3), cx_shr(p2, 3));
    nb.re = nb.re - tzz.re;
    nb.im = nb.im - tzz.im;
    nb = cx_shr(nb, 16);
    nc = cx_mul(q3, q1);
    nc.re = nc.re - t.re; nc.im = nc.im - t.im;
    nd = cx_mul(q3, p2);
    nd.re = nd.re + tz2.re; nd.im = nd.im + tz2.im;
    nd = cx_shr(nd, 6);
    ent = div_entry(na, s21, den, K_AD, sat); {res.a_re, res.a_im} = ent;
    ent = div_entry(nb, s21, den, K_B, sat);  {res.b_re, res.b_im} = ent;
    ent = div_entry(nc, s21, den, K_C, sat);  {res.c_re, res.c_im} = ent;
    ent = div_entry(nd, s21, den, K_AD, sat); {res.d_re, res.d_im} = ent;
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_abcd.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", abcd);
      end else begin
        abcd_t exp_w;
        exp_w = pending_abcd.pop_front();
        if (abcd !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected a %h %h b %h %h c %h %h d %h %h st %0d",
                     exp_w.a_re, exp_w.a_im, exp_w.b_re, exp_w.b_im,
                     exp_w.c_re, exp_w.c_im, exp_w.d_re, exp_w.d_im, exp_w.status);
            $display("          actual   a %h %h b %h %h c %h %h d %h %h st %0d",
                     abcd.a_re, abcd.a_im, abcd.b_re, abcd.b_im,
                     abcd.c_re, abcd.c_im, abcd.d_re, abcd.d_im, abcd.status);
          end
        end
      end
    end
  end

  // Send one word; start stays high for a following word
  task automatic send_word(smat_t w);
    start <= 1'b1;
    smat <= w;
    do @(posedge clk); while (busy);
    pending_abcd.push_back(convert_smat(w));
  endtask

  // With one chance in four, while idle gaps are enabled, drop start for a random gap after a word
  task automatic maybe_idle();
    if (idle_en && $urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_abcd.size() != 0) @(posedge clk);
  endtask

  // Write all four impedance registers while idle
  task automatic set_refs(logic [15:0] r1, logic [15:0] i1,
                          logic [15:0] r2, logic [15:0] i2);
    logic [15:0] vals[4];
    drain();
    vals = '{r1, i1, r2, i2};
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1'b1;
      wr_index <= 2'(i);
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    z1_re_q = r1; z1_im_q = i1; z2_re_q = r2; z2_im_q = i2;
    root_q = int_sqrt(({48'd0, r1} * {48'd0, r2}) << 16);
    // let the root recompute settle
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic smat_t rand_smat();
    smat_t w;
    int    kind;
    kind = $urandom_range(9, 0);
    w = smat_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind < 6) begin
      // passive-looking matrix, each real and imaginary part in [-1, 1)
      w.s11_re = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s11_im = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s12_re = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s12_im = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s21_re = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s21_im = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s22_re = 16'($signed($urandom_range(16383, 0)) - 8192);
      w.s22_im = 16'($signed($urandom_range(16383, 0)) - 8192);
    end else if (kind == 6) begin
      w.s21_re = '0;
      w.s21_im = '0;
    end else if (kind == 7) begin
      // tiny transmission drives saturation
      w.s21_re = 16'($signed($urandom_range(8, 0)) - 4);
      w.s21_im = 16'($signed($urandom_range(8, 0)) - 4);
    end
    return w;
  endfunction

  task automatic test_directed();
    smat_t w;
    // all-zero matrix: divide error
    send_word('0);
    // matched thru: A = D = 1
    w = '0; w.s12_re = 16'sd8192; w.s21_re = 16'sd8192;
    send_word(w);
    w = '0; w.s21_im = 16'sd8192; w.s12_im = 16'sd8192; w.s11_re = 16'sd4096;
    send_word(w);
    send_word({8{16'sh7fff}});
    send_word({8{16'sh8000}});
    send_word({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
               16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    // smallest S21 with large numerator: saturation
    w = {8{16'sh7fff}}; w.s21_re = 16'sd1; w.s21_im = 16'sd0;
    send_word(w);
    w = {8{16'sh8000}}; w.s21_re = 16'sd0; w.s21_im = -16'sd1;
    send_word(w);
    w = '0; w.s21_re = 16'sh8000; w.s12_re = 16'sh8000;
    send_word(w);
    w = '0; w.s11_re = 16'sd8192; w.s22_re = 16'sd8192; w.s21_re = 16'sd8192;
    send_word(w);
    w = '0; w.s11_re = -16'sd8192; w.s22_re = -16'sd8192; w.s21_re = 16'sd8192;
    send_word(w);
    w = {8{16'shffff}};
    send_word(w);
    for (int i = 0; i < 8; i++) begin
      send_word(rand_smat());
      maybe_idle();
    end
    drain();
  endtask

  // Extremes of the reference impedances
  task automatic test_ref_extremes();
    logic [15:0] r[5][4];
    r = '{'{16'd64, 16'h8000, 16'd64, 16'h7fff},
          '{16'hffff, 16'h7fff, 16'hffff, 16'h8000},
          '{16'd64, 16'h0000, 16'hffff, 16'h0000},
          '{16'd0, 16'h0000, 16'd3200, 16'h0000},
          '{16'd3200, 16'h0040, 16'd0, 16'hffc0}};
    for (int c = 0; c < 5; c++) begin
      set_refs(r[c][0], r[c][1], r[c][2], r[c][3]);
      send_word({8{16'sh7fff}});
      send_word({8{16'sh8000}});
      for (int i = 0; i < 6; i++) send_word(rand_smat());
      maybe_idle();
    end
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 250 == 0) begin
        if ($urandom_range(1, 0) == 0)
          set_refs(16'($urandom_range(65535, 64)), 16'($urandom),
                   16'($urandom_range(65535, 64)), 16'($urandom));
        else
          set_refs(16'($urandom_range(6400, 64)), 16'($urandom_range(6400, 0)),
                   16'($urandom_range(6400, 64)), 16'($urandom_range(6400, 0)));
      end
      // hold the sender until the pipeline is empty
      if (i == 600) drain();
      if (i == RAND_WORDS - 150) idle_en = 1'b0;
      send_word(rand_smat());
      maybe_idle();
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ref_extremes();
    set_refs(REF_RE_RESET, 16'h0000, REF_RE_RESET, 16'h0000);
    test_random();
    while (pending_abcd.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
